/* hdl/smt_pkg.sv */
// Shared widths, link types and the midpoint function of the sorted midpoint threshold block.
package smt_pkg;

  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned MAX_ITEMS_DEF = 64;

  typedef logic signed [VALUE_W-1:0] value_t;

  // What a cell shows to its neighbors: its value, whether it holds one,
  // and whether that value is greater than the value being inserted.
  typedef struct packed {
    value_t value;
    logic   valid;
    logic   gt;
  } cell_link_t;

  // Common control seen by every cell of the chain.
  typedef struct packed {
    logic   ins;
    logic   shift;
    logic   clr;
    value_t v;
  } cell_ctrl_t;

  // floor((a + b) / 2) formed on a sum one bit wider than the operands.
  function automatic value_t midpoint(input value_t a, input value_t b);
    logic signed [VALUE_W:0] sum;
    sum = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
    return sum[VALUE_W:1];
  endfunction

endpackage

/* hdl/smt_if.sv */
// Valid/ready channel interfaces for feature values in and thresholds out.
interface smt_in_if;
  import smt_pkg::*;
  logic   valid;
  logic   ready;
  value_t value;
  logic   last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface smt_out_if;
  import smt_pkg::*;
  logic   valid;
  logic   ready;
  value_t threshold;
  logic   final_res;
  logic   overflow;

  modport source (output valid, output threshold, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input threshold, input final_res, input overflow,
                  output ready);
endinterface

/* hdl/smt_cell.sv */
// One cell of the insertion chain: holds one sorted value and its valid bit.
module smt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smt_pkg::cell_ctrl_t ctrl_i,
  input  smt_pkg::cell_link_t prev_i,
  input  smt_pkg::cell_link_t next_i,
  output smt_pkg::cell_link_t link_o
);
  import smt_pkg::*;

  value_t value_q;
  logic   valid_q;
  logic   gt;

  assign gt     = valid_q && (value_q > ctrl_i.v);
  assign link_o = '{value: value_q, valid: valid_q, gt: gt};

  // Valid bit: set when the insertion reaches the first empty cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clr) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= next_i.valid;
    end else if (ctrl_i.ins && !valid_q && (prev_i.gt || prev_i.valid)) begin
      valid_q <= 1'b1;
    end
  end

  // A cell whose value is greater than the new one makes room: it takes the
  // left neighbor's value if that one moves too, else the new value.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      value_q <= next_i.value;
    end else if (ctrl_i.ins) begin
      if (gt || !valid_q) begin
        if (prev_i.gt) begin
          value_q <= prev_i.value;
        end else if (gt || prev_i.valid) begin
          value_q <= ctrl_i.v;
        end
      end
    end
  end

endmodule

/* hdl/smt_chain.sv */
// Row of insertion cells linked to both neighbors; shows the two head values.
module smt_chain #(
  parameter int unsigned MAX_ITEMS = smt_pkg::MAX_ITEMS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smt_pkg::cell_ctrl_t ctrl_i,
  output smt_pkg::value_t     head0_o,
  output smt_pkg::value_t     head1_o,
  output logic                tail_valid_o
);
  import smt_pkg::*;

  cell_link_t links [MAX_ITEMS];
  cell_link_t prevs [MAX_ITEMS];
  cell_link_t nexts [MAX_ITEMS];

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    if (i == 0) begin : g_head
      // Left of the head stands an always valid slot that never moves.
      assign prevs[i] = '{value: '0, valid: 1'b1, gt: 1'b0};
    end else begin : g_mid
      assign prevs[i] = links[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign nexts[i] = '{value: '0, valid: 1'b0, gt: 1'b0};
    end else begin : g_body
      assign nexts[i] = links[i+1];
    end

    smt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_i),
      .prev_i (prevs[i]),
      .next_i (nexts[i]),
      .link_o (links[i])
    );
  end

  assign head0_o      = links[0].value;
  assign head1_o      = links[1].value;
  assign tail_valid_o = links[MAX_ITEMS-1].valid;

endmodule

/* hdl/sorted_midpoint_thresholds_top.sv */
// Top level of the sorted midpoint threshold block: control, output register, checks.
//
// Usage: feature values arrive on in_i, one request per value, the final one
// of a run marked by last. Each value is inserted into a row of MAX_ITEMS
// sorting cells in the cycle it is accepted; in_i.ready stays high while loading.
// Values beyond MAX_ITEMS are dropped and the run's results carry overflow.
// After the marked value is accepted, in_i.ready stays low while the chain
// shifts toward its head; in the emit state the output register takes one
// threshold per cycle while it is empty or out_o.ready is high, each the
// midpoint of the two head cells. A run that stores N values gives N-1
// thresholds (one, the value itself, if N is one), the last marked by
// final_res.
// A full output register holds while out_o.ready is low, and the chain waits.
// The next run may start loading while the final threshold still waits.
// Reset empties the chain and clears the output valid; no sweep is needed.
module sorted_midpoint_thresholds_top #(
  parameter int unsigned MAX_ITEMS = smt_pkg::MAX_ITEMS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  smt_in_if.sink    in_i,
  smt_out_if.source out_o
);
  import smt_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] rem_q;
  logic             dropped_q;
  logic             run_ovf_q;
  logic             single_q;
  logic             out_valid_q;
  value_t           threshold_q;
  logic             final_q;
  logic             overflow_q;

  cell_ctrl_t       ctrl;
  value_t           head0;
  value_t           head1;
  logic             tail_valid;
  logic             accept;
  logic             full;
  logic             load_out;
  logic [CNT_W-1:0] cnt_next;

  assign in_i.ready = (state_q == ST_LOAD);
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (cnt_q == CNT_W'(MAX_ITEMS));
  assign cnt_next   = cnt_q + ((accept && !full) ? CNT_W'(1) : CNT_W'(0));
  assign load_out   = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  assign ctrl.ins   = accept && !full;
  assign ctrl.v     = in_i.value;
  assign ctrl.shift = load_out && (rem_q != CNT_W'(1));
  assign ctrl.clr   = load_out && (rem_q == CNT_W'(1));

  smt_chain #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .head0_o      (head0),
    .head1_o      (head1),
    .tail_valid_o (tail_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      rem_q       <= '0;
      dropped_q   <= 1'b0;
      run_ovf_q   <= 1'b0;
      single_q    <= 1'b0;
      out_valid_q <= 1'b0;
      threshold_q <= '0;
      final_q     <= 1'b0;
      overflow_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && !load_out) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_LOAD: begin
          if (accept) begin
            cnt_q <= cnt_next;
            if (in_i.last) begin
              state_q   <= ST_EMIT;
              single_q  <= (cnt_next == CNT_W'(1));
              rem_q     <= (cnt_next == CNT_W'(1)) ? CNT_W'(1) : cnt_next - CNT_W'(1);
              run_ovf_q <= dropped_q || full;
            end else if (full) begin
              dropped_q <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            threshold_q <= single_q ? head0 : midpoint(head0, head1);
            final_q     <= (rem_q == CNT_W'(1));
            overflow_q  <= run_ovf_q;
            if (rem_q == CNT_W'(1)) begin
              state_q   <= ST_LOAD;
              cnt_q     <= '0;
              dropped_q <= 1'b0;
            end else begin
              rem_q <= rem_q - CNT_W'(1);
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.threshold = threshold_q;
  assign out_o.final_res = final_q;
  assign out_o.overflow  = overflow_q;

  // The emission countdown never reaches zero while thresholds remain.
  a_rem_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (rem_q != '0))
    else $error("emission count reached zero while emitting");

  // The stored count never exceeds the chain length.
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ITEMS))
    else $error("value count beyond capacity");

  // While loading, the tail cell is occupied exactly when the count says full.
  a_tail_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (tail_valid == full))
    else $error("tail cell occupancy disagrees with value count");

  // A marked request always starts an emission.
  a_last_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.last) |=> (state_q == ST_EMIT))
    else $error("final request did not start emission");

endmodule
